// File: hdl/olids_pkg.sv
package olids_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int VAL_W = 32;
	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int TYPE_W = 2;
	localparam int STATUS_W = 3;
	localparam int POS_W = 5;

	localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_DELETE = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DELETED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;

	typedef struct packed {
		logic [TYPE_W-1:0] req_type;
		logic signed [VAL_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] entry_count;
	} rsp_item_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INS,
		OP_DEL
	} cell_op_t;

	typedef struct packed {
		logic cmp;
		cell_op_t op;
	} cell_ctl_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_APPLY
	} fsm_state_t;

endpackage

// File: hdl/ordered_list_insert_delete_search.sv
// Ordered list of signed 32-bit values held in a row of cells, front at cell 0.
// Request channel (req_valid, req_stall, req): an item is an insert at the
// front, a delete of the first matching entry, or a search for the first
// matching entry. Response channel (rsp_valid, rsp_stall, rsp): one item per
// request with status, 1-based position of a found search, and entry count.
// In the accept cycle every cell registers the compare of its value with the
// key; in the apply state the first-match chain along the cells resolves and
// the row shifts in one step. The response is registered and appears the
// cycle after that. One item is in flight at a time: a new request is not
// taken until the earlier one has left the apply state, since each item
// needs the compare register in each cell followed by the match chain.
// A new request is taken while an earlier response still waits. If the
// response register is still blocked by rsp_stall when a request is ready to
// finish, the request waits and the list is left untouched until it frees.
// Reset empties the list; it accepts a request as soon as reset is released.
module ordered_list_insert_delete_search (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  olids_pkg::req_item_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output olids_pkg::rsp_item_t rsp
);

	localparam int Depth = olids_pkg::LIST_DEPTH;
	localparam int IdxW = olids_pkg::IDX_W;
	localparam int CntW = olids_pkg::CNT_W;
	localparam int PosW = olids_pkg::POS_W;

	olids_pkg::fsm_state_t state_q, state_d;
	olids_pkg::cell_ctl_t ctl;
	olids_pkg::cell_op_t op_sel;
	olids_pkg::rsp_item_t rsp_q;

	logic [olids_pkg::TYPE_W-1:0] type_q;
	logic [olids_pkg::VAL_W-1:0] value_q;
	logic [CntW-1:0] len_q, len_d;
	logic rsp_valid_q;
	logic accept, apply_go, full, found;
	logic [olids_pkg::STATUS_W-1:0] status_d;
	logic [CntW-1:0] pos_d;
	logic [IdxW-1:0] idx;

	logic [olids_pkg::VAL_W-1:0] cell_val [Depth];
	logic [Depth-1:0] cell_occ;
	logic [Depth-1:0] cell_first;
	logic [Depth:0] seen;

	assign req_stall = (state_q != olids_pkg::FSM_IDLE);
	assign accept = req_valid & ~req_stall;
	assign apply_go = (state_q == olids_pkg::FSM_APPLY) && (!rsp_valid_q || !rsp_stall);
	assign full = cell_occ[Depth-1];
	assign found = seen[Depth];

	assign seen[0] = 1'b0;

	for (genvar i = 0; i < Depth; i++) begin : g_cell
		logic [olids_pkg::VAL_W-1:0] lv, rv;
		logic lo, ro;

		if (i == 0) begin : g_front
			assign lv = value_q;
			assign lo = 1'b1;
		end else begin : g_mid_l
			assign lv = cell_val[i-1];
			assign lo = cell_occ[i-1];
		end

		if (i == Depth - 1) begin : g_back
			assign rv = cell_val[i];
			assign ro = 1'b0;
		end else begin : g_mid_r
			assign rv = cell_val[i+1];
			assign ro = cell_occ[i+1];
		end

		olids_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.key(req.value),
			.left_val(lv),
			.left_occ(lo),
			.right_val(rv),
			.right_occ(ro),
			.seen_in(seen[i]),
			.val(cell_val[i]),
			.occ(cell_occ[i]),
			.seen_out(seen[i+1]),
			.first(cell_first[i])
		);
	end

	always_comb begin
		idx = '0;
		for (int i = 0; i < Depth; i++) begin
			if (cell_first[i]) idx = idx | IdxW'(i);
		end
	end

	always_comb begin
		op_sel = olids_pkg::OP_HOLD;
		status_d = olids_pkg::ST_NOT_FOUND;
		pos_d = '0;
		len_d = len_q;
		priority if (type_q == olids_pkg::REQ_INSERT) begin
			if (full) begin
				status_d = olids_pkg::ST_FULL;
			end else begin
				op_sel = olids_pkg::OP_INS;
				status_d = olids_pkg::ST_INSERTED;
				len_d = len_q + CntW'(1);
			end
		end else if (type_q == olids_pkg::REQ_DELETE) begin
			if (found) begin
				op_sel = olids_pkg::OP_DEL;
				status_d = olids_pkg::ST_DELETED;
				len_d = len_q - CntW'(1);
			end
		end else if (type_q == olids_pkg::REQ_SEARCH) begin
			if (found) begin
				status_d = olids_pkg::ST_FOUND;
				pos_d = CntW'(idx) + CntW'(1);
			end
		end else begin
			status_d = olids_pkg::ST_NOT_FOUND;
		end
	end

	always_comb begin
		ctl.cmp = accept;
		ctl.op = apply_go ? op_sel : olids_pkg::OP_HOLD;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			olids_pkg::FSM_IDLE: if (req_valid) state_d = olids_pkg::FSM_APPLY;
			olids_pkg::FSM_APPLY: if (apply_go) state_d = olids_pkg::FSM_IDLE;
			default: state_d = olids_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olids_pkg::FSM_IDLE;
			len_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (apply_go) begin
				len_q <= len_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req.req_type;
			value_q <= req.value;
		end
		if (apply_go) begin
			rsp_q.status <= status_d;
			rsp_q.position <= PosW'(pos_d);
			rsp_q.entry_count <= PosW'(len_d);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_len_matches_occ: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_occ) == int'(len_q))
		else $error("occupied cells disagree with the entry count");

	a_occ_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_occ & (cell_occ + Depth'(1))) == '0))
		else $error("occupied cells are not a contiguous run from the front");

	a_first_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_first))
		else $error("more than one cell claims the first match");

	a_found_has_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == olids_pkg::ST_FOUND |-> rsp_q.position != '0)
		else $error("found search reported position zero");

	a_no_apply_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == olids_pkg::FSM_IDLE |-> ctl.op == olids_pkg::OP_HOLD)
		else $error("list changed with no request in flight");

endmodule

// File: hdl/olids_cell.sv
module olids_cell (
	input  logic clk,
	input  logic arst_n,
	input  olids_pkg::cell_ctl_t ctl,
	input  logic [olids_pkg::VAL_W-1:0] key,
	input  logic [olids_pkg::VAL_W-1:0] left_val,
	input  logic left_occ,
	input  logic [olids_pkg::VAL_W-1:0] right_val,
	input  logic right_occ,
	input  logic seen_in,
	output logic [olids_pkg::VAL_W-1:0] val,
	output logic occ,
	output logic seen_out,
	output logic first
);

	logic [olids_pkg::VAL_W-1:0] val_q;
	logic occ_q;
	logic hit_q;

	// A cell takes part in a delete when the first match is here or further front.
	assign first = hit_q & ~seen_in;
	assign seen_out = seen_in | hit_q;
	assign val = val_q;
	assign occ = occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (ctl.cmp) begin
				hit_q <= occ_q && (val_q == key);
			end
			unique case (ctl.op)
				olids_pkg::OP_INS: occ_q <= left_occ;
				olids_pkg::OP_DEL: if (seen_out) occ_q <= right_occ;
				default: occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			olids_pkg::OP_INS: val_q <= left_val;
			olids_pkg::OP_DEL: if (seen_out) val_q <= right_val;
			default: val_q <= val_q;
		endcase
	end

endmodule

// File: tb/ordered_list_checker.sv
`timescale 1ns / 1ps

module ordered_list_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  olids_pkg::req_item_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  olids_pkg::rsp_item_t rsp,
	output int fail_count,
	output int outstanding
);

	// Shadow copy of the list; entry 0 is the front.
	logic [olids_pkg::VAL_W-1:0] list_mem [olids_pkg::LIST_DEPTH];
	int list_len;
	olids_pkg::rsp_item_t reply_q [$];
	olids_pkg::rsp_item_t want;
	int errs;

	function automatic olids_pkg::rsp_item_t predict_list_reply(input olids_pkg::req_item_t r);
		olids_pkg::rsp_item_t o;
		int hit;
		o = '0;
		o.status = olids_pkg::ST_NOT_FOUND;
		hit = -1;
		for (int i = 0; i < list_len; i++)
			if (hit < 0 && list_mem[i] == r.value)
				hit = i;
		case (r.req_type)
			olids_pkg::REQ_INSERT: begin
				if (list_len >= olids_pkg::LIST_DEPTH) begin
					o.status = olids_pkg::ST_FULL;
				end else begin
					for (int i = list_len; i > 0; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[0] = r.value;
					list_len++;
					o.status = olids_pkg::ST_INSERTED;
				end
			end
			olids_pkg::REQ_DELETE: begin
				if (hit >= 0) begin
					for (int i = hit; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
					o.status = olids_pkg::ST_DELETED;
				end
			end
			olids_pkg::REQ_SEARCH: begin
				if (hit >= 0) begin
					o.status = olids_pkg::ST_FOUND;
					o.position = olids_pkg::POS_W'(hit + 1);
				end
			end
			default: begin
			end
		endcase
		o.entry_count = olids_pkg::POS_W'(list_len);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			reply_q.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			errs = 0;
			// The expectation is queued first so that ordering holds at any latency.
			if (req_valid && !req_stall)
				reply_q.push_back(predict_list_reply(req));
			if (rsp_valid && !rsp_stall) begin
				if (reply_q.size() == 0) begin
					$display("%0t: unexpected item: status %0d position %0d count %0d",
						$time, rsp.status, rsp.position, rsp.entry_count);
					errs++;
				end else begin
					want = reply_q.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, rsp.status);
						errs++;
					end
					if (rsp.position !== want.position) begin
						$display("%0t: position expected %0d, got %0d",
							$time, want.position, rsp.position);
						errs++;
					end
					if (rsp.entry_count !== want.entry_count) begin
						$display("%0t: entry_count expected %0d, got %0d",
							$time, want.entry_count, rsp.entry_count);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			outstanding <= reply_q.size();
		end
	end

endmodule

// File: tb/ordered_list_insert_delete_search_tb.sv
`timescale 1ns / 1ps

module ordered_list_insert_delete_search_tb;

	localparam logic [olids_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic [olids_pkg::VAL_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [olids_pkg::VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
	localparam logic [olids_pkg::VAL_W-1:0] VAL_NEG1 = 32'hffff_ffff;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	olids_pkg::req_item_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	olids_pkg::rsp_item_t rsp;
	int fail_count;
	int outstanding;
	int idle_mode;
	int stall_left = 0;

	// A small set of keys so that deletes and searches hit and duplicates build up.
	logic [olids_pkg::VAL_W-1:0] key_pool [8] = '{VAL_MIN, VAL_MAX, 32'd0, VAL_NEG1,
		32'd1, 32'd5, 32'd42, 32'hffff_fff9};

	ordered_list_insert_delete_search u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	ordered_list_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Response back-pressure: mostly short stalls, now and then a long one.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (idle_mode != 0 &&
				$urandom_range(99) < ((idle_mode == 2) ? 30 : 8)) begin
			stall_left <= ($urandom_range(99) < 85) ? $urandom_range(3) :
				$urandom_range(40, 10);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (idle_mode == 0)
			return 0;
		if (idle_mode == 1)
			return (r < 80) ? 0 : (r < 97) ? $urandom_range(2, 1) : $urandom_range(20, 5);
		return (r < 50) ? 0 : (r < 85) ? $urandom_range(3, 1) : $urandom_range(30, 4);
	endfunction

	function automatic logic [olids_pkg::VAL_W-1:0] pick_value();
		if ($urandom_range(7) < 5)
			return key_pool[$urandom_range(7)];
		return $urandom;
	endfunction

	// Holds the item until it is taken, then idles for a random gap.
	task automatic send_request(input logic [olids_pkg::TYPE_W-1:0] kind,
			input logic [olids_pkg::VAL_W-1:0] v);
		int n;
		req <= {kind, v};
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		n = gap_len();
		if (n > 0) begin
			req_valid <= 1'b0;
			req <= {olids_pkg::TYPE_W'($urandom_range(3)), olids_pkg::VAL_W'($urandom)};
			repeat (n) @(posedge clk);
		end
	endtask

	initial begin
		int sent_random;
		int phase_len;
		int ins_pct;
		int r;
		logic [olids_pkg::TYPE_W-1:0] kind;

		req_valid = 1'b0;
		req = '0;
		idle_mode = 0;
		arst_n = 1'b0;
		sent_random = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_mode = 1;
		// Operations on the empty list, including the unused request code.
		send_request(olids_pkg::REQ_SEARCH, 32'd0);
		send_request(olids_pkg::REQ_DELETE, VAL_MIN);
		send_request(REQ_UNUSED, VAL_NEG1);
		// Extreme values and a duplicate at the front.
		send_request(olids_pkg::REQ_INSERT, VAL_MIN);
		send_request(olids_pkg::REQ_INSERT, VAL_MAX);
		send_request(olids_pkg::REQ_INSERT, VAL_NEG1);
		send_request(olids_pkg::REQ_INSERT, VAL_NEG1);
		send_request(olids_pkg::REQ_SEARCH, VAL_NEG1);
		send_request(olids_pkg::REQ_SEARCH, VAL_MIN);
		send_request(olids_pkg::REQ_DELETE, VAL_NEG1);
		send_request(olids_pkg::REQ_DELETE, VAL_MIN);
		// Fill to the depth, then one insert too many and a search of the back entry.
		for (int i = 0; i < olids_pkg::LIST_DEPTH - 2; i++)
			send_request(olids_pkg::REQ_INSERT, olids_pkg::VAL_W'(i));
		send_request(olids_pkg::REQ_INSERT, 32'd77);
		send_request(olids_pkg::REQ_SEARCH, VAL_MAX);

		// Phases lean to inserts, to deletes and searches, or neither; the list sweeps empty to full.
		while (sent_random < 1000) begin
			phase_len = $urandom_range(60, 10);
			idle_mode = $urandom_range(2);
			case ($urandom_range(2))
				0: ins_pct = 85;
				1: ins_pct = 15;
				default: ins_pct = 50;
			endcase
			repeat (phase_len) begin
				r = $urandom_range(99);
				if (r < 3) begin
					kind = REQ_UNUSED;
				end else if ($urandom_range(99) < ins_pct) begin
					kind = olids_pkg::REQ_INSERT;
				end else begin
					kind = $urandom_range(1) ? olids_pkg::REQ_DELETE : olids_pkg::REQ_SEARCH;
				end
				send_request(kind, pick_value());
				sent_random++;
			end
		end

		req_valid <= 1'b0;
		idle_mode = 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: ordered_list_insert_delete_search.f
hdl/olids_pkg.sv
hdl/olids_cell.sv
hdl/ordered_list_insert_delete_search.sv
tb/ordered_list_checker.sv
tb/ordered_list_insert_delete_search_tb.sv
